FILE: hdl/stprs_pkg.sv
// ----------------------------------------------------------------------------
// Segment tree range-sum package
// Field widths, defaults, sequencer states and operation codes shared by the
// segment tree range-sum block.
// ----------------------------------------------------------------------------
package stprs_pkg;

  localparam int IDX_W      = 16;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;
  localparam int LEAVES_DEF = 65536;

  typedef enum logic {
    FUNC_ASSIGN = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_A_RD,
    ST_A_WR,
    ST_Q_CHK,
    ST_Q_HI,
    ST_Q_SH,
    ST_Q_DONE
  } state_t;

endpackage

FILE: hdl/segment_tree_point_assign_range_sum.sv
// ----------------------------------------------------------------------------
// Segment tree point-assign range-sum
// Sum tree over LEAVES unsigned 32-bit values with point assign and
// inclusive range-sum query.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the node store;
// in_stall stays high until it ends. Each word is then handled alone and
// in_stall is high while it is in work. The node store has one read port
// with registered data and all sums go through one 48-bit adder: an assign
// does one read and one write per tree level, and a query does up to two
// reads and two adds per level; an empty range reads nothing. An assign to
// an index past the last leaf is dropped. A finished query sum sits in an
// output register, so the next word can be taken while it waits; a query
// that finishes while the previous sum is still stalled holds in_stall high
// until that sum is taken.
module segment_tree_point_assign_range_sum #(
  parameter int LEAVES = stprs_pkg::LEAVES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [stprs_pkg::IDX_W-1:0]  in_index,
  input  logic [stprs_pkg::VAL_W-1:0]  in_value,
  input  logic [stprs_pkg::IDX_W-1:0]  in_range_start,
  input  logic [stprs_pkg::IDX_W-1:0]  in_range_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stprs_pkg::SUM_W-1:0]  out_range_sum
);

  localparam int NW = $clog2(2 * LEAVES);

  logic                        wr_en;
  logic [NW-1:0]               wr_addr;
  logic [stprs_pkg::SUM_W-1:0] wr_data;
  logic                        rd_en;
  logic [NW-1:0]               rd_addr;
  logic [stprs_pkg::SUM_W-1:0] rd_data;

  stprs_ctrl #(
    .LEAVES (LEAVES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_range_sum  (out_range_sum),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  stprs_ram #(
    .DEPTH (2 * LEAVES),
    .AW    (NW),
    .DW    (stprs_pkg::SUM_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: hdl/stprs_ram.sv
// ----------------------------------------------------------------------------
// Segment tree node store
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module stprs_ram #(
  parameter int DEPTH = 2 * stprs_pkg::LEAVES_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = stprs_pkg::SUM_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/stprs_ctrl.sv
// ----------------------------------------------------------------------------
// Segment tree sequencer
// Clears the node store after reset, walks leaf-to-root on assign and
// bottom-up over the node interval on query, all through one 48-bit adder.
// ----------------------------------------------------------------------------
module stprs_ctrl #(
  parameter int LEAVES = stprs_pkg::LEAVES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [stprs_pkg::IDX_W-1:0]  in_index,
  input  logic [stprs_pkg::VAL_W-1:0]  in_value,
  input  logic [stprs_pkg::IDX_W-1:0]  in_range_start,
  input  logic [stprs_pkg::IDX_W-1:0]  in_range_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stprs_pkg::SUM_W-1:0]  out_range_sum,
  output logic                         wr_en,
  output logic [$clog2(2*LEAVES)-1:0]  wr_addr,
  output logic [stprs_pkg::SUM_W-1:0]  wr_data,
  output logic                         rd_en,
  output logic [$clog2(2*LEAVES)-1:0]  rd_addr,
  input  logic [stprs_pkg::SUM_W-1:0]  rd_data
);

  localparam int NW = $clog2(2 * LEAVES);
  localparam int PW = NW + 1;
  localparam int CW = ((NW > stprs_pkg::IDX_W) ? NW : stprs_pkg::IDX_W) + 1;
  localparam logic [CW-1:0] LEAF_C = CW'(LEAVES);
  localparam logic [CW-1:0] LAST_C = CW'(LEAVES - 1);
  localparam logic [NW-1:0] CLR_END = NW'(2 * LEAVES - 1);

  stprs_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]                clr_r, clr_nxt;
  logic [PW-1:0]                node_r, node_nxt;
  logic [PW-1:0]                lo_r, lo_nxt;
  logic [PW-1:0]                hi_r, hi_nxt;
  logic [stprs_pkg::SUM_W-1:0]  cur_r, cur_nxt;
  logic [stprs_pkg::SUM_W-1:0]  acc_r, acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [stprs_pkg::SUM_W-1:0]  out_sum_r, out_sum_nxt;

  logic [CW-1:0]                idx_ext, start_ext, end_ext, last_c;
  logic [CW-1:0]                leaf_c, lo_c, hi_c;
  logic                         q_empty;
  logic [PW-1:0]                sib, par, hm1, lo_up;
  logic [stprs_pkg::SUM_W-1:0]  add_a, add_sum;

  // range setup: clamp the end to the last leaf, then map onto node indexes
  assign idx_ext   = CW'(in_index);
  assign start_ext = CW'(in_range_start);
  assign end_ext   = CW'(in_range_end);
  assign last_c    = (end_ext > LAST_C) ? LAST_C : end_ext;
  assign q_empty   = start_ext > last_c;
  assign leaf_c    = idx_ext + LEAF_C;
  assign lo_c      = start_ext + LEAF_C;
  assign hi_c      = last_c + LEAF_C + CW'(1);

  assign sib   = node_r ^ PW'(1);
  assign par   = node_r >> 1;
  assign hm1   = hi_r - PW'(1);
  assign lo_up = (lo_r + PW'(lo_r[0])) >> 1;

  // the one shared adder
  assign add_a   = (state_r == stprs_pkg::ST_A_WR) ? cur_r : acc_r;
  assign add_sum = add_a + rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stprs_pkg::ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    cur_r     <= cur_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    out_sum_nxt   = out_sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      stprs_pkg::ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == CLR_END) begin
          state_nxt = stprs_pkg::ST_IDLE;
        end
      end
      stprs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_func == stprs_pkg::FUNC_ASSIGN) begin
            // out-of-range index: word is dropped
            if (idx_ext < LEAF_C) begin
              wr_en     = 1'b1;
              wr_addr   = leaf_c[NW-1:0];
              wr_data   = stprs_pkg::SUM_W'(in_value);
              cur_nxt   = stprs_pkg::SUM_W'(in_value);
              node_nxt  = leaf_c[PW-1:0];
              state_nxt = stprs_pkg::ST_A_RD;
            end
          end else begin
            acc_nxt = '0;
            lo_nxt  = lo_c[PW-1:0];
            hi_nxt  = hi_c[PW-1:0];
            state_nxt = q_empty ? stprs_pkg::ST_Q_DONE : stprs_pkg::ST_Q_CHK;
          end
        end
      end
      stprs_pkg::ST_A_RD: begin
        if (node_r == PW'(1)) begin
          state_nxt = stprs_pkg::ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = sib[NW-1:0];
          state_nxt = stprs_pkg::ST_A_WR;
        end
      end
      stprs_pkg::ST_A_WR: begin
        wr_en     = 1'b1;
        wr_addr   = par[NW-1:0];
        wr_data   = add_sum;
        cur_nxt   = add_sum;
        node_nxt  = par;
        state_nxt = stprs_pkg::ST_A_RD;
      end
      stprs_pkg::ST_Q_CHK: begin
        if (lo_r < hi_r) begin
          rd_en     = lo_r[0];
          rd_addr   = lo_r[NW-1:0];
          state_nxt = stprs_pkg::ST_Q_HI;
        end else begin
          state_nxt = stprs_pkg::ST_Q_DONE;
        end
      end
      stprs_pkg::ST_Q_HI: begin
        if (lo_r[0]) begin
          acc_nxt = add_sum;
        end
        rd_en     = hi_r[0];
        rd_addr   = hm1[NW-1:0];
        state_nxt = stprs_pkg::ST_Q_SH;
      end
      stprs_pkg::ST_Q_SH: begin
        if (hi_r[0]) begin
          acc_nxt = add_sum;
        end
        lo_nxt    = lo_up;
        hi_nxt    = hi_r >> 1;
        state_nxt = stprs_pkg::ST_Q_CHK;
      end
      stprs_pkg::ST_Q_DONE: begin
        // wait until the output word slot is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = stprs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stprs_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall      = (state_r != stprs_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same node");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stprs_pkg::ST_CLR) |-> !out_valid_r)
    else $error("result word during clearing pass");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == stprs_pkg::ST_Q_DONE))
    else $error("result word not from a finished query");

  a_walk_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stprs_pkg::ST_A_RD) |-> (node_r != '0))
    else $error("assign walk reached node zero");

  a_query_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stprs_pkg::ST_Q_CHK) |-> (lo_r <= hi_r))
    else $error("query interval crossed");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for segment_tree_point_assign_range_sum
// Sends assign and query words over the valid/stall input channel and keeps
// its own copy of the sum tree. Every range_sum word is checked in order
// against that copy. Both channels get random gaps in two of the three phases.
// ----------------------------------------------------------------------------
class sum_tree_tracker_t;
  localparam int unsigned LEAVES = stprs_pkg::LEAVES_DEF;

  // node 1 is the root, leaf i sits at LEAVES+i
  bit [stprs_pkg::SUM_W-1:0] node_sum [2*LEAVES];
  bit [stprs_pkg::SUM_W-1:0] expected_sums [$];
  int n_assign, n_query, n_empty, n_checked, n_errors;

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  function void write_leaf(int unsigned pos, bit [stprs_pkg::VAL_W-1:0] val);
    int unsigned node;
    if (pos >= LEAVES) return;
    node = LEAVES + pos;
    node_sum[node] = stprs_pkg::SUM_W'(val);
    while (node > 1) begin
      node = node >> 1;
      node_sum[node] = node_sum[2*node] + node_sum[2*node+1];
    end
  endfunction

  function bit [stprs_pkg::SUM_W-1:0] span_sum(int unsigned first, int unsigned last);
    bit [stprs_pkg::SUM_W-1:0] acc;
    int unsigned lo, hi;
    acc = '0;
    if (last >= LEAVES) last = LEAVES - 1;
    if (first > last) return '0;
    // half-open node interval, walked up from the leaves
    lo = first + LEAVES;
    hi = last + 1 + LEAVES;
    while (lo < hi) begin
      if (lo & 1) begin
        acc = acc + node_sum[lo];
        lo++;
      end
      if (hi & 1) begin
        hi--;
        acc = acc + node_sum[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  function void note_word(stprs_pkg::func_t op, bit [stprs_pkg::IDX_W-1:0] idx,
                          bit [stprs_pkg::VAL_W-1:0] val,
                          bit [stprs_pkg::IDX_W-1:0] rs, bit [stprs_pkg::IDX_W-1:0] re);
    if (op == stprs_pkg::FUNC_ASSIGN) begin
      write_leaf(32'(idx), val);
      n_assign++;
    end else begin
      n_query++;
      if (rs > re) n_empty++;
      expected_sums.insert(expected_sums.size(), span_sum(32'(rs), 32'(re)));
    end
  endfunction

  task check_sum(logic [stprs_pkg::SUM_W-1:0] got);
    bit [stprs_pkg::SUM_W-1:0] want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("range_sum %h with no query pending", got));
      return;
    end
    want = expected_sums.pop_front();
    n_checked++;
    if (got !== want)
      report_mismatch($sformatf("range_sum got %h expected %h", got, want));
  endtask
endclass

module testbench;
  localparam int unsigned LIMIT_TIME = 10_000_000;
  localparam int unsigned LAST_POS   = stprs_pkg::LEAVES_DEF - 1;
  localparam int unsigned TAIL_CYC   = 64;
  localparam logic [stprs_pkg::IDX_W-1:0] TOP_POS = stprs_pkg::IDX_W'(LAST_POS);

  logic                        clk;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_func        = 1'b0;
  logic [stprs_pkg::IDX_W-1:0] in_index       = '0;
  logic [stprs_pkg::VAL_W-1:0] in_value       = '0;
  logic [stprs_pkg::IDX_W-1:0] in_range_start = '0;
  logic [stprs_pkg::IDX_W-1:0] in_range_end   = '0;
  logic                        out_stall      = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic [stprs_pkg::SUM_W-1:0] out_range_sum;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hot_base     = 0;

  sum_tree_tracker_t tracker = new;

  segment_tree_point_assign_range_sum u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_range_sum  (out_range_sum)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #LIMIT_TIME;
    $display("timeout with %0d sums pending", tracker.expected_sums.size());
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_sum(out_range_sum);
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  task automatic send_word(stprs_pkg::func_t op, logic [stprs_pkg::IDX_W-1:0] idx,
                           logic [stprs_pkg::VAL_W-1:0] val,
                           logic [stprs_pkg::IDX_W-1:0] rs,
                           logic [stprs_pkg::IDX_W-1:0] re);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= op;
    in_index       <= idx;
    in_value       <= val;
    in_range_start <= rs;
    in_range_end   <= re;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(op, idx, val, rs, re);
  endtask

  // hold the sender until every pending sum has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_sums.size() != 0) @(posedge clk);
  endtask

  function automatic logic [stprs_pkg::IDX_W-1:0] rand_pos();
    return stprs_pkg::IDX_W'($urandom_range(LAST_POS));
  endfunction

  function automatic logic [stprs_pkg::IDX_W-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return stprs_pkg::IDX_W'(hot_base + $urandom_range(63));
    if (r < 45) return stprs_pkg::IDX_W'($urandom_range(3));
    if (r < 50) return stprs_pkg::IDX_W'(LAST_POS - $urandom_range(3));
    return rand_pos();
  endfunction

  function automatic logic [stprs_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  task automatic random_word();
    logic [stprs_pkg::IDX_W-1:0] a, b;
    int unsigned r;
    if ($urandom_range(99) < 3) hot_base = $urandom_range(LAST_POS - 63);
    a = pick_pos();
    b = pick_pos();
    r = $urandom_range(99);
    if ($urandom_range(99) < 45) begin
      send_word(stprs_pkg::FUNC_ASSIGN, a, pick_value(), rand_pos(), rand_pos());
    end else if (r < 8) begin
      // wraps at the top, still leaves start > end
      if (a == b) b = stprs_pkg::IDX_W'(a + 1);
      send_word(stprs_pkg::FUNC_QUERY, rand_pos(), $urandom,
                (a > b) ? a : b, (a > b) ? b : a);
    end else if (r < 14) begin
      send_word(stprs_pkg::FUNC_QUERY, rand_pos(), $urandom, '0, TOP_POS);
    end else begin
      if (r < 55) begin
        a = stprs_pkg::IDX_W'(hot_base + $urandom_range(63));
        b = stprs_pkg::IDX_W'(hot_base + $urandom_range(63));
      end
      send_word(stprs_pkg::FUNC_QUERY, rand_pos(), $urandom,
                (a < b) ? a : b, (a < b) ? b : a);
    end
  endtask

  task automatic run_directed();
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, '0, TOP_POS);
    send_word(stprs_pkg::FUNC_ASSIGN, '0, '1, '1, '1);
    send_word(stprs_pkg::FUNC_ASSIGN, TOP_POS, '1, '0, '0);
    send_word(stprs_pkg::FUNC_ASSIGN, 16'h5555, 32'hAAAA_AAAA, 16'hAAAA, 16'h5555);
    send_word(stprs_pkg::FUNC_ASSIGN, 16'hAAAA, 32'h5555_5555, 16'h5555, 16'hAAAA);
    send_word(stprs_pkg::FUNC_ASSIGN, 16'd1, 32'd1, '0, '0);
    send_word(stprs_pkg::FUNC_QUERY,  '1, '1, '0, TOP_POS);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, '0, '0);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, TOP_POS, TOP_POS);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, 16'd1, 16'd0);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, TOP_POS, '0);
    send_word(stprs_pkg::FUNC_QUERY,  16'h5555, 32'h5555_5555, 16'h5555, 16'hAAAA);
    send_word(stprs_pkg::FUNC_QUERY,  16'hAAAA, 32'hAAAA_AAAA, 16'h5556, 16'hAAA9);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, 16'd1, stprs_pkg::IDX_W'(LAST_POS - 1));
    send_word(stprs_pkg::FUNC_ASSIGN, '0, '0, '0, '0);
    send_word(stprs_pkg::FUNC_ASSIGN, TOP_POS, 32'h1234_5678, '0, '0);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, '0, TOP_POS);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, '0, 16'd1);
    // pair straddling the root split
    send_word(stprs_pkg::FUNC_ASSIGN, 16'd32767, '1, '0, '0);
    send_word(stprs_pkg::FUNC_ASSIGN, 16'd32768, '1, '0, '0);
    send_word(stprs_pkg::FUNC_QUERY,  '0, '0, 16'd32767, 16'd32768);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 29;
    rcv_idle_pct = 55;
    run_directed();
    wait_drained();
    repeat (650) random_word();
    wait_drained();

    snd_idle_pct = 55;
    rcv_idle_pct = 29;
    repeat (650) random_word();
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (650) random_word();
    wait_drained();
    repeat (TAIL_CYC) @(posedge clk);

    $display("covered %0d assigns and %0d queries, %0d of them with empty ranges",
             tracker.n_assign, tracker.n_query, tracker.n_empty);
    $display("%0d range sums checked, %0d mismatches", tracker.n_checked,
             tracker.n_errors);
    if (tracker.n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: segment_tree_point_assign_range_sum.f
hdl/stprs_pkg.sv
hdl/stprs_ram.sv
hdl/stprs_ctrl.sv
hdl/segment_tree_point_assign_range_sum.sv
tb/testbench.sv
